### rtl/dic_pkg.sv
// Shared types and constants for the duplicate request cache.
`timescale 1ns / 1ps

package dic_pkg;

  // Table geometry.
  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);

  // Field widths.
  localparam int ADDR_W   = 32;
  localparam int ID_W     = 32;
  localparam int METRIC_W = 32;
  localparam int REFW_W   = 8;
  localparam int TIME_W   = 32;
  localparam int EXP_W    = TIME_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REFW = CFG_IDX_W'(1);

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0] LIFETIME_RESET = TIME_W'(1000);
  localparam logic [REFW_W-1:0] MAX_REFW_RESET = REFW_W'(2);
  localparam logic [REFW_W-1:0] REFW_MAX       = '1;

  // One stored table row.
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [ID_W-1:0]     id;
    logic [METRIC_W-1:0] metric;
    logic [REFW_W-1:0]   refw;
    logic [EXP_W-1:0]    expiry;
  } entry_row_t;

  // Key and time of the request under test.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
  } query_t;

  // Outcome of comparing one row against the request.
  typedef struct packed {
    logic expired;
    logic live;
    logic match;
  } cmp_status_t;

endpackage

### rtl/dic_entry_ram.sv
// Table row memory: one write port and one registered read port.
`timescale 1ns / 1ps

module dic_entry_ram
  import dic_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_row_t       wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_row_t       rdata
);

  entry_row_t mem [NUM_ENTRIES];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/dic_cmp.sv
// Compare unit shared by every step of the table scan.
`timescale 1ns / 1ps

module dic_cmp
  import dic_pkg::*;
(
  input  logic        row_valid,
  input  entry_row_t  row,
  input  query_t      query,
  output cmp_status_t status
);

  // A valid row whose expiry lies before now is freed; a live row may match.
  always_comb begin
    status.expired = row_valid && (row.expiry < {1'b0, query.now});
    status.live    = row_valid && !status.expired;
    status.match   = status.live && (row.addr == query.addr) && (row.id == query.id);
  end

endmodule

### rtl/duplicate_id_cache_with_reforward.sv
// Top level of the duplicate request cache with limited re-forwarding.
`timescale 1ns / 1ps

// For each accepted request the sequencer walks the table one row per cycle
// through the single read port of the row memory and the shared compare unit,
// freeing expired rows and finding the first match and the first free row on
// the way, then decides and writes the hit or new row in a final step. A new
// request is taken whenever the sequencer is idle, even while the previous
// result still waits on the output; that final step then waits until the
// previous result is taken, and the input stays closed meanwhile. Valid bits
// live in flip-flops and clear at reset, so no clearing pass is needed.
// Configuration writes are always accepted.
module duplicate_id_cache_with_reforward
  import dic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_W-1:0]     origin_addr,
  input  logic [ID_W-1:0]       request_id,
  input  logic [METRIC_W-1:0]   path_metric,
  input  logic                  unlimited,
  input  logic [TIME_W-1:0]     now_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  is_duplicate,
  output logic                  table_full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t state;

  // Configuration registers.
  logic [TIME_W-1:0] entry_lifetime;
  logic [REFW_W-1:0] max_reforwards;

  // Request held for the whole scan.
  query_t              query;
  logic [METRIC_W-1:0] q_metric;
  logic                q_unl;

  // Scan bookkeeping.
  logic [NUM_ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       ev_idx;
  logic                   issue_done;
  logic                   ev_pend;
  logic                   hit_found;
  logic                   free_found;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [METRIC_W-1:0]    hit_metric;
  logic [REFW_W-1:0]      hit_refw;

  // Memory and compare unit.
  entry_row_t  rd_row;
  entry_row_t  wr_row;
  logic        wr_en;
  logic [IDX_W-1:0] wr_idx;
  cmp_status_t status;

  logic             in_accept;
  logic             out_free;
  logic             ev_valid;
  logic [EXP_W-1:0] new_expiry;
  logic             better;
  logic             limited;
  logic             dup_next;
  logic             full_next;

  assign in_ready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign ev_valid  = entry_valid[ev_idx];

  dic_entry_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_row),
    .raddr (rd_idx),
    .rdata (rd_row)
  );

  dic_cmp u_cmp (
    .row_valid (ev_valid),
    .row       (rd_row),
    .query     (query),
    .status    (status)
  );

  // Decision for the final step: refresh, improve, insert or report full.
  always_comb begin
    new_expiry = {1'b0, query.now} + {1'b0, entry_lifetime};
    better     = q_metric < hit_metric;
    limited    = !q_unl && (hit_refw >= max_reforwards);
    wr_row.addr   = query.addr;
    wr_row.id     = query.id;
    wr_row.expiry = new_expiry;
    wr_row.metric = q_metric;
    wr_row.refw   = '0;
    dup_next   = 1'b0;
    full_next  = 1'b0;
    wr_idx     = free_idx;
    if (hit_found) begin
      wr_idx = hit_idx;
      wr_row.metric = hit_metric;
      wr_row.refw   = hit_refw;
      if (better && !limited) begin
        wr_row.metric = q_metric;
        if (!q_unl && (hit_refw != REFW_MAX)) begin
          wr_row.refw = hit_refw + REFW_W'(1);
        end
      end else begin
        dup_next = 1'b1;
      end
    end else if (!free_found) begin
      full_next = 1'b1;
    end
    wr_en = (state == FINISH) && out_free && (hit_found || free_found);
  end

  // Sequencer, valid bits, configuration and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      entry_valid    <= '0;
      entry_lifetime <= LIFETIME_RESET;
      max_reforwards <= MAX_REFW_RESET;
      out_valid      <= 1'b0;
      is_duplicate   <= 1'b0;
      table_full     <= 1'b0;
      rd_idx         <= '0;
      ev_idx         <= '0;
      issue_done     <= 1'b0;
      ev_pend        <= 1'b0;
      hit_found      <= 1'b0;
      free_found     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LIFETIME: entry_lifetime <= cfg_data[TIME_W-1:0];
          CFG_MAX_REFW: max_reforwards <= cfg_data[REFW_W-1:0];
          default: ;
        endcase
      end
      // A taken result clears unless the final step loads the next one.
      if (out_valid && out_ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_accept) begin
            state      <= SCAN;
            rd_idx     <= '0;
            issue_done <= 1'b0;
            ev_pend    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
          end
        end
        SCAN: begin
          // Issue the next read while judging the row read last cycle.
          if (!issue_done) begin
            ev_idx  <= rd_idx;
            ev_pend <= 1'b1;
            if (rd_idx == IDX_W'(NUM_ENTRIES - 1)) begin
              issue_done <= 1'b1;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end else begin
            ev_pend <= 1'b0;
          end
          if (ev_pend) begin
            if (status.expired) begin
              entry_valid[ev_idx] <= 1'b0;
            end
            if (status.match && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= ev_idx;
            end
            if (!status.live && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= ev_idx;
            end
            if (ev_idx == IDX_W'(NUM_ENTRIES - 1)) begin
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          if (out_free) begin
            if (!hit_found && free_found) begin
              entry_valid[free_idx] <= 1'b1;
            end
            is_duplicate <= dup_next;
            table_full   <= full_next;
            out_valid    <= 1'b1;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Request payload and the stored fields of the first hit.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      query.addr <= origin_addr;
      query.id   <= request_id;
      query.now  <= now_time;
      q_metric   <= path_metric;
      q_unl      <= unlimited;
    end
    if ((state == SCAN) && ev_pend && status.match && !hit_found) begin
      hit_metric <= rd_row.metric;
      hit_refw   <= rd_row.refw;
    end
  end

endmodule

### rtl/dic_checker.sv
// Port-level checks for the duplicate request cache and their binding.
`timescale 1ns / 1ps

module dic_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_duplicate,
  input logic table_full
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_duplicate) && $stable(table_full))
    else $error("result changed while stalled");

  // An accepted request makes the block busy for its scan.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a scan should be running");

  // A result only appears at the end of a scan.
  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a scan");

  // A full table is only reported for a miss, never with duplicate.
  a_full_not_dup: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_duplicate && table_full))
    else $error("duplicate and full reported together");

endmodule

bind duplicate_id_cache_with_reforward dic_checker u_dic_checker (.*);
